>>> hw/rtl/utsu_pkg.sv
// shared types, constants and helper functions for the utf-8 glyph table search unit
// no dependencies; imported by every module of the block
package utsu_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int LEN_W       = 3;
    localparam int DATA_W      = 32;
    localparam int MASK_W      = 64;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_FIND = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // token that walks the cell row for a read or a find
    typedef struct packed {
        logic              vld;
        logic              find;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [CNT_W-1:0]  limit;
        logic [CNT_W-1:0]  count;
        logic              any;
        logic [IDX_W-1:0]  pos;
    } t_tok;

    // table write port, broadcast to every cell
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] bytes;
        logic [LEN_W-1:0]  len;
    } t_wr;

    function automatic logic [LEN_W-1:0] lead_len(input logic [7:0] b);
        logic [LEN_W-1:0] l;
        if ((b & 8'h80) == 8'h00) begin
            l = 3'd1;
        end else if ((b & 8'hE0) == 8'hC0) begin
            l = 3'd2;
        end else if ((b & 8'hF0) == 8'hE0) begin
            l = 3'd3;
        end else if ((b & 8'hF8) == 8'hF0) begin
            l = 3'd4;
        end else begin
            l = 3'd1;
        end
        return l;
    endfunction

    function automatic logic [DATA_W-1:0] query_mask(input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] m;
        case (len)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

>>> hw/rtl/utsu_cell.sv
// one table entry plus one stage of the search chain
// depends on utsu_pkg for the token and write port types and for query_mask
module utsu_cell
    import utsu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_cell_idx,
    input  logic [CNT_W-1:0] i_count,
    input  t_wr              i_wr,
    input  logic             i_clr,
    input  t_tok             i_tok,
    output t_tok             o_tok,
    output logic             o_hit
);

    logic [DATA_W-1:0] r_bytes;
    logic [LEN_W-1:0]  r_len;
    t_tok              r_tok;
    t_tok              n_tok;
    logic              r_hit;
    logic              n_hit;
    logic              live;
    logic              same;

    assign live = {1'b0, i_cell_idx} < i_count;
    assign same = (r_len == i_tok.len) &&
                  ((r_bytes & query_mask(i_tok.len)) == i_tok.data);

    always_comb begin
        n_tok = i_tok;
        n_hit = r_hit;
        if (i_tok.vld && live) begin
            if (i_tok.find) begin
                if (same) begin
                    if (!i_tok.any) begin
                        n_tok.any = 1'b1;
                        n_tok.pos = i_cell_idx;
                    end
                    if (i_tok.count < i_tok.limit) begin
                        n_tok.count = i_tok.count + 7'd1;
                        n_hit       = 1'b1;
                    end
                end
            end else if (i_tok.pos == i_cell_idx) begin
                n_tok.any  = 1'b1;
                n_tok.data = r_bytes;
                n_tok.len  = r_len;
            end
        end
        if (i_clr) begin
            n_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_cell_idx)) begin
            r_bytes <= i_wr.bytes;
            r_len   <= i_wr.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_tok <= n_tok;
            r_hit <= n_hit;
        end
    end

    assign o_tok = r_tok;
    assign o_hit = r_hit;

endmodule

>>> hw/rtl/utsu_loader.sv
// palette string parser: splits bytes into utf-8 characters and writes the table
// depends on utsu_pkg for lead_len, the write port type and status codes
module utsu_loader
    import utsu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output t_wr              o_wr,
    output logic [1:0]       o_status,
    output logic [CNT_W-1:0] o_next_count,
    output logic [CNT_W-1:0] o_count
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [23:0]       r_pbytes;
    logic [23:0]       n_pbytes;
    logic [1:0]        r_have;
    logic [1:0]        n_have;
    logic [LEN_W-1:0]  r_need;
    logic [LEN_W-1:0]  n_need;
    logic              r_closed;
    logic              n_closed;
    logic [DATA_W-1:0] value;

    always_comb begin
        n_count  = r_count;
        n_pbytes = r_pbytes;
        n_have   = r_have;
        n_need   = r_need;
        n_closed = r_closed;
        o_wr     = '0;
        o_status = ST_OK;
        value    = '0;
        if (i_load) begin
            // a load after a closed string starts a fresh table
            if (r_closed) begin
                n_count  = '0;
                n_pbytes = '0;
                n_have   = '0;
                n_need   = '0;
            end
            n_closed = 1'b0;
            if (n_have == 2'd0) begin
                n_need   = lead_len(i_byte);
                n_pbytes = '0;
            end
            value = {8'h00, n_pbytes} | ({24'h0, i_byte} << {n_have, 3'b000});
            if (({1'b0, n_have} + 3'd1) >= n_need) begin
                if (n_count < CNT_W'(TABLE_DEPTH)) begin
                    o_wr.en    = 1'b1;
                    o_wr.idx   = n_count[IDX_W-1:0];
                    o_wr.bytes = value;
                    o_wr.len   = n_need;
                    n_count    = n_count + 7'd1;
                end else begin
                    o_status = ST_FULL;
                end
                n_pbytes = '0;
                n_have   = '0;
                n_need   = '0;
            end else begin
                n_pbytes = value[23:0];
                n_have   = n_have + 2'd1;
            end
            // string end drops any partial trailing character
            if (i_last) begin
                n_pbytes = '0;
                n_have   = '0;
                n_need   = '0;
                n_closed = 1'b1;
                if (n_count == '0) begin
                    o_status = ST_EMPTY;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pbytes <= '0;
            r_have   <= '0;
            r_need   <= '0;
            r_closed <= 1'b1;
        end else begin
            r_count  <= n_count;
            r_pbytes <= n_pbytes;
            r_have   <= n_have;
            r_need   <= n_need;
            r_closed <= n_closed;
        end
    end

    assign o_next_count = n_count;
    assign o_count      = r_count;

endmodule

>>> hw/rtl/utf8_glyph_table_search_unit.sv
// Palette bytes are cut into utf-8 characters and kept in a row of 64 cells, one
// character per cell. A load word or an unused command puts its result word in a pending
// register and from there in the output register; the next word is taken only once the
// pending register has emptied. A read or find word sends a token down the cell row, one
// cell per cycle; the block is busy until the token leaves the end of the row. A finished
// result sits in an output register, so a new word is accepted while the previous result
// still waits to be taken.
// depends on utsu_pkg, utsu_loader and utsu_cell
module utf8_glyph_table_search_unit
    import utsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [DATA_W-1:0] i_query_char,
    input  logic [LEN_W-1:0]  i_query_len,
    input  logic [CNT_W-1:0]  i_match_limit,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [IDX_W-1:0]  o_found_index,
    output logic [DATA_W-1:0] o_entry_value,
    output logic [LEN_W-1:0]  o_entry_len,
    output logic [CNT_W-1:0]  o_match_count,
    output logic [MASK_W-1:0] o_match_mask,
    output logic [CNT_W-1:0]  o_stored_count
);

    logic                   accept;
    logic                   walk;
    t_wr                    wr;
    logic [1:0]             ld_status;
    logic [CNT_W-1:0]       ld_next_count;
    logic [CNT_W-1:0]       count;
    t_tok                   w_tok [0:TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_hit;
    logic [TABLE_DEPTH-1:0] w_tok_vld;
    t_tok                   r_launch;
    t_tok                   tail;

    logic                   r_busy;
    logic                   r_pend;
    logic                   r_out_vld;
    logic [1:0]             r_p_status;
    logic [IDX_W-1:0]       r_p_found;
    logic [DATA_W-1:0]      r_p_value;
    logic [LEN_W-1:0]       r_p_len;
    logic [CNT_W-1:0]       r_p_mcount;
    logic [MASK_W-1:0]      r_p_mask;
    logic [CNT_W-1:0]       r_p_stored;
    logic [1:0]             r_o_status;
    logic [IDX_W-1:0]       r_o_found;
    logic [DATA_W-1:0]      r_o_value;
    logic [LEN_W-1:0]       r_o_len;
    logic [CNT_W-1:0]       r_o_mcount;
    logic [MASK_W-1:0]      r_o_mask;
    logic [CNT_W-1:0]       r_o_stored;

    assign o_stall = r_busy || r_pend;
    assign accept  = i_valid && !o_stall;
    assign walk    = (i_command == CMD_READ) || (i_command == CMD_FIND);

    utsu_loader u_loader (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept && (i_command == CMD_LOAD)),
        .i_byte       (i_data_byte),
        .i_last       (i_last_byte),
        .o_wr         (wr),
        .o_status     (ld_status),
        .o_next_count (ld_next_count),
        .o_count      (count)
    );

    assign w_tok[0] = r_launch;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            utsu_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cell_idx (IDX_W'(g)),
                .i_count    (count),
                .i_wr       (wr),
                .i_clr      (accept),
                .i_tok      (w_tok[g]),
                .o_tok      (w_tok[g+1]),
                .o_hit      (w_hit[g])
            );
            assign w_tok_vld[g] = w_tok[g+1].vld;
        end
    endgenerate

    assign tail = w_tok[TABLE_DEPTH];

    // launch register feeds the first cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch.vld <= 1'b0;
        end else begin
            r_launch.vld <= accept && walk;
        end
        if (accept) begin
            r_launch.find  <= (i_command == CMD_FIND);
            r_launch.data  <= (i_command == CMD_FIND) ?
                              (i_query_char & query_mask(i_query_len)) : '0;
            r_launch.len   <= (i_command == CMD_FIND) ? i_query_len : '0;
            r_launch.limit <= i_match_limit;
            r_launch.count <= '0;
            r_launch.any   <= 1'b0;
            r_launch.pos   <= (i_command == CMD_FIND) ? '0 : i_entry_index;
        end
    end

    // control: busy while the token walks, pending while a result waits for the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept && walk) begin
                r_busy <= 1'b1;
            end else if (tail.vld) begin
                r_busy <= 1'b0;
            end
            if ((accept && !walk) || tail.vld) begin
                r_pend <= 1'b1;
            end else if (r_pend && (!r_out_vld || !i_stall)) begin
                r_pend <= 1'b0;
            end
            if (r_pend) begin
                if (!r_out_vld || !i_stall) begin
                    r_out_vld <= 1'b1;
                end
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !walk) begin
            r_p_status <= (i_command == CMD_LOAD) ? ld_status : ST_MISS;
            r_p_found  <= '0;
            r_p_value  <= '0;
            r_p_len    <= '0;
            r_p_mcount <= '0;
            r_p_mask   <= '0;
            r_p_stored <= (i_command == CMD_LOAD) ? ld_next_count : count;
        end else if (tail.vld) begin
            r_p_status <= tail.any ? ST_OK : ST_MISS;
            r_p_found  <= (tail.find && tail.any) ? tail.pos : '0;
            r_p_value  <= tail.find ? '0 : tail.data;
            r_p_len    <= tail.find ? '0 : tail.len;
            r_p_mcount <= tail.find ? tail.count : '0;
            r_p_mask   <= tail.find ? MASK_W'(w_hit) : '0;
            r_p_stored <= count;
        end
        if (r_pend && (!r_out_vld || !i_stall)) begin
            r_o_status <= r_p_status;
            r_o_found  <= r_p_found;
            r_o_value  <= r_p_value;
            r_o_len    <= r_p_len;
            r_o_mcount <= r_p_mcount;
            r_o_mask   <= r_p_mask;
            r_o_stored <= r_p_stored;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_status       = r_o_status;
    assign o_found_index  = r_o_found;
    assign o_entry_value  = r_o_value;
    assign o_entry_len    = r_o_len;
    assign o_match_count  = r_o_mcount;
    assign o_match_mask   = r_o_mask;
    assign o_stored_count = r_o_stored;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vld))
        else $error("more than one token in the cell row");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CNT_W'(TABLE_DEPTH))
        else $error("stored count above table depth");

    a_mask_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones(o_match_mask) == 32'(o_match_count)))
        else $error("match mask disagrees with match count");

    a_first_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_match_count != '0)) |-> o_match_mask[o_found_index])
        else $error("first match missing from match mask");

    a_busy_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail.vld |-> (r_busy && !r_pend))
        else $error("token finished while block not busy");

endmodule
